// ===== design/prfp_pkg.sv =====
// ----------------------------------------------------------------------------
// prfp_pkg - shared constants and types for the pulse rate block
// widths, register map, reset values and window limits
// ----------------------------------------------------------------------------
package prfp_pkg;

	// sample path
	localparam int SAMPLE_BITS = 24;
	localparam int IN_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

	// window
	localparam int WINDOW_MAX = 1024;
	localparam int WINDOW_MIN = 3;
	localparam int POS_BITS = $clog2(WINDOW_MAX);
	localparam int LEN_BITS = POS_BITS + 1;

	// register widths
	localparam int GAIN_BITS = 17;
	localparam int THR_BITS = 24;
	localparam int WLEN_BITS = 11;
	localparam int RGAIN_BITS = 16;
	localparam int LIMIT_BITS = 25;

	// compare width for the window length clamp
	localparam int CMP_BITS = (LEN_BITS > WLEN_BITS) ? LEN_BITS : WLEN_BITS;

	// q16 filter
	localparam int Q16_SHIFT = 16;
	localparam logic [GAIN_BITS-1:0] Q16_ONE = GAIN_BITS'(65536);

	// results
	localparam int PEAK_BITS = 9;
	localparam logic [PEAK_BITS-1:0] PEAK_MAX = '1;
	localparam int RATE_BITS = PEAK_BITS + RGAIN_BITS;
	localparam int OUT_FIELD_BITS = PEAK_BITS + RATE_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

	// configuration port
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 5;
	localparam int REG_IDX_BITS = 3;
	localparam logic [REG_IDX_BITS-1:0] REG_FILTER_GAIN = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_PEAK_THRESHOLD = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_RATE_GAIN = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_HIGH_RATE_LIMIT = 3'd4;

	// reset values
	localparam logic [GAIN_BITS-1:0] FILTER_GAIN_RST = GAIN_BITS'(6554);
	localparam logic [THR_BITS-1:0] PEAK_THRESHOLD_RST = THR_BITS'(1000);
	localparam logic [WLEN_BITS-1:0] WINDOW_LENGTH_RST = WLEN_BITS'(200);
	localparam logic [RGAIN_BITS-1:0] RATE_GAIN_RST = RGAIN_BITS'(108);
	localparam logic [LIMIT_BITS-1:0] HIGH_RATE_LIMIT_RST = LIMIT_BITS'(10000);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [GAIN_BITS-1:0] gain_t;

endpackage

// ===== design/prfp_ema.sv =====
// ----------------------------------------------------------------------------
// prfp_ema - q16 exponential low-pass step
// y = prev + floor(g * (x - prev) / 65536), gain clamped to one
// ----------------------------------------------------------------------------
module prfp_ema (
	input  prfp_pkg::sample_t sample,
	input  prfp_pkg::sample_t prev,
	input  prfp_pkg::gain_t   gain,
	output prfp_pkg::sample_t filtered
);

	localparam int DIFF_BITS = prfp_pkg::SAMPLE_BITS + 1;
	localparam int GS_BITS = prfp_pkg::GAIN_BITS + 1;
	localparam int PROD_BITS = GS_BITS + DIFF_BITS;
	localparam int SUM_BITS = PROD_BITS - prfp_pkg::Q16_SHIFT;

	prfp_pkg::gain_t               gain_c;
	logic signed [GS_BITS-1:0]     gain_s;
	logic signed [DIFF_BITS-1:0]   diff;
	logic signed [PROD_BITS-1:0]   prod;
	logic signed [SUM_BITS-1:0]    step;
	logic signed [SUM_BITS-1:0]    prev_s;
	logic signed [SUM_BITS-1:0]    sum;

	// g*x + (1-g)*prev rewritten so that one multiplier does the work
	always_comb begin
		gain_c = (gain > prfp_pkg::Q16_ONE) ? prfp_pkg::Q16_ONE : gain;
		gain_s = signed'({1'b0, gain_c});
		diff = signed'({1'b0, sample}) - signed'({1'b0, prev});
		prod = PROD_BITS'(gain_s) * PROD_BITS'(diff);
		// arithmetic shift gives the floor for negative steps
		step = prod[PROD_BITS-1:prfp_pkg::Q16_SHIFT];
		prev_s = signed'({{(SUM_BITS - prfp_pkg::SAMPLE_BITS){1'b0}}, prev});
		sum = prev_s + step;
	end

	assign filtered = sum[prfp_pkg::SAMPLE_BITS-1:0];

endmodule

// ===== design/pulse_rate_from_filtered_peaks.sv =====
// ----------------------------------------------------------------------------
// pulse_rate_from_filtered_peaks - heart rate from low-pass filtered peaks
// windowed ema filter, peak counter and rate/limit output per window
// ----------------------------------------------------------------------------
// One infrared sample is taken per request on the input stream, and the block
// can take a sample in every clock cycle. Samples are grouped into windows of
// window_length samples (clamped to 3..1024). The first sample of a window is
// used as is, later ones pass through a q16 exponential low-pass filter. A
// filtered sample strictly above both neighbours and above peak_threshold is
// a peak. The last sample of each window produces one output request: the
// peak count, the rate in hundredths of bpm (count times rate_gain) and a
// flag for rate above high_rate_limit; all other samples produce nothing.
// A window result reaches the output through registers in order: the input
// register feeds the filter/peak stage (whose one multiplier and feedback
// of the previous filtered value set the one-sample-per-cycle rate), the
// window count is registered for the rate multiply, and the product goes to
// the output register. Results wait in the output register and one stage
// behind it, so input is only held back when both are full and another
// window ends. The user must write registers through the apb-style port only
// while the block is idle; the block itself does not enforce this.
module pulse_rate_from_filtered_peaks (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input stream: [23:0] ir_sample
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [prfp_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
	// output stream: [8:0] peak_count, [33:9] rate_centi_bpm, rest zero
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [prfp_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
	// [0] rate_high
	output logic                                   m_axis_tuser,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [prfp_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  logic [prfp_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [prfp_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                   pready
);

	// configuration registers
	prfp_pkg::gain_t                       filter_gain_q;
	logic [prfp_pkg::THR_BITS-1:0]         peak_threshold_q;
	logic [prfp_pkg::WLEN_BITS-1:0]        window_length_q;
	logic [prfp_pkg::RGAIN_BITS-1:0]       rate_gain_q;
	logic [prfp_pkg::LIMIT_BITS-1:0]       high_rate_limit_q;

	logic                                  cfg_wr;
	logic [prfp_pkg::REG_IDX_BITS-1:0]     reg_idx;

	// window state
	prfp_pkg::sample_t                     last_q;
	prfp_pkg::sample_t                     before_last_q;
	logic [prfp_pkg::POS_BITS-1:0]         pos_q;
	logic [prfp_pkg::PEAK_BITS-1:0]        peaks_q;

	// pipeline
	logic                                  valid_s1;
	prfp_pkg::sample_t                     x_s1;
	logic                                  valid_s2;
	logic [prfp_pkg::PEAK_BITS-1:0]        peaks_s2;

	// output register
	logic                                  out_valid_q;
	logic [prfp_pkg::PEAK_BITS-1:0]        peak_count_q;
	logic [prfp_pkg::RATE_BITS-1:0]        rate_q;
	logic                                  rate_high_q;

	// stage 1 logic
	prfp_pkg::sample_t                     smoothed;
	prfp_pkg::sample_t                     f_s1;
	logic [prfp_pkg::CMP_BITS-1:0]         wl_ext;
	logic [prfp_pkg::CMP_BITS-1:0]         eff_len;
	logic [prfp_pkg::CMP_BITS-1:0]         pos_next;
	logic                                  end_s1;
	logic                                  is_peak;
	logic [prfp_pkg::PEAK_BITS-1:0]        peaks_next;

	// stage 2 logic
	logic [prfp_pkg::RATE_BITS-1:0]        rate_s2;

	// flow control
	logic                                  out_free;
	logic                                  go_s2;
	logic                                  free_s2;
	logic                                  go_s1;
	logic                                  accept;

	// ------------------------------------------------------------------------
	// configuration port, registers at byte address 4*index
	// ------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign reg_idx = paddr[prfp_pkg::APB_ADDR_BITS-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_gain_q <= prfp_pkg::FILTER_GAIN_RST;
			peak_threshold_q <= prfp_pkg::PEAK_THRESHOLD_RST;
			window_length_q <= prfp_pkg::WINDOW_LENGTH_RST;
			rate_gain_q <= prfp_pkg::RATE_GAIN_RST;
			high_rate_limit_q <= prfp_pkg::HIGH_RATE_LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				prfp_pkg::REG_FILTER_GAIN: begin
					filter_gain_q <= pwdata[prfp_pkg::GAIN_BITS-1:0];
				end
				prfp_pkg::REG_PEAK_THRESHOLD: begin
					peak_threshold_q <= pwdata[prfp_pkg::THR_BITS-1:0];
				end
				prfp_pkg::REG_WINDOW_LENGTH: begin
					window_length_q <= pwdata[prfp_pkg::WLEN_BITS-1:0];
				end
				prfp_pkg::REG_RATE_GAIN: begin
					rate_gain_q <= pwdata[prfp_pkg::RGAIN_BITS-1:0];
				end
				prfp_pkg::REG_HIGH_RATE_LIMIT: begin
					high_rate_limit_q <= pwdata[prfp_pkg::LIMIT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			prfp_pkg::REG_FILTER_GAIN:
				prdata = prfp_pkg::APB_DATA_BITS'(filter_gain_q);
			prfp_pkg::REG_PEAK_THRESHOLD:
				prdata = prfp_pkg::APB_DATA_BITS'(peak_threshold_q);
			prfp_pkg::REG_WINDOW_LENGTH:
				prdata = prfp_pkg::APB_DATA_BITS'(window_length_q);
			prfp_pkg::REG_RATE_GAIN:
				prdata = prfp_pkg::APB_DATA_BITS'(rate_gain_q);
			prfp_pkg::REG_HIGH_RATE_LIMIT:
				prdata = prfp_pkg::APB_DATA_BITS'(high_rate_limit_q);
			default:
				prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// flow control: a result only needs space downstream at a window end
	// ------------------------------------------------------------------------
	assign out_free = ~out_valid_q | m_axis_tready;
	assign go_s2 = valid_s2 & out_free;
	assign free_s2 = ~valid_s2 | out_free;
	assign go_s1 = valid_s1 & (~end_s1 | free_s2);
	assign s_axis_tready = ~valid_s1 | go_s1;
	assign accept = s_axis_tvalid & s_axis_tready;

	// ------------------------------------------------------------------------
	// input register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= s_axis_tdata[prfp_pkg::SAMPLE_BITS-1:0];
		end
	end

	// ------------------------------------------------------------------------
	// stage 1: filter, peak test on the previous sample, window end
	// ------------------------------------------------------------------------
	prfp_ema u_ema (
		.sample   (x_s1),
		.prev     (last_q),
		.gain     (filter_gain_q),
		.filtered (smoothed)
	);

	always_comb begin
		// first sample of a window passes unfiltered
		f_s1 = (pos_q == '0) ? x_s1 : smoothed;

		// clamp window length to the supported range
		wl_ext = prfp_pkg::CMP_BITS'(window_length_q);
		if (wl_ext < prfp_pkg::CMP_BITS'(prfp_pkg::WINDOW_MIN)) begin
			eff_len = prfp_pkg::CMP_BITS'(prfp_pkg::WINDOW_MIN);
		end else if (wl_ext > prfp_pkg::CMP_BITS'(prfp_pkg::WINDOW_MAX)) begin
			eff_len = prfp_pkg::CMP_BITS'(prfp_pkg::WINDOW_MAX);
		end else begin
			eff_len = wl_ext;
		end

		// ends also when a shortened window is already past its length
		pos_next = prfp_pkg::CMP_BITS'(pos_q) + prfp_pkg::CMP_BITS'(1);
		end_s1 = (pos_next >= eff_len);

		// previous sample now has both neighbours
		is_peak = (pos_q >= prfp_pkg::POS_BITS'(2)) && (last_q > before_last_q) &&
			(last_q > f_s1) && (last_q > peak_threshold_q) &&
			(peaks_q != prfp_pkg::PEAK_MAX);
		peaks_next = is_peak ? (peaks_q + prfp_pkg::PEAK_BITS'(1)) : peaks_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			before_last_q <= '0;
			pos_q <= '0;
			peaks_q <= '0;
		end else if (go_s1) begin
			if (end_s1) begin
				last_q <= '0;
				before_last_q <= '0;
				pos_q <= '0;
				peaks_q <= '0;
			end else begin
				last_q <= f_s1;
				before_last_q <= last_q;
				pos_q <= pos_next[prfp_pkg::POS_BITS-1:0];
				peaks_q <= peaks_next;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stage 2: window count waiting for the rate multiply
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1 && end_s1) begin
			valid_s2 <= 1'b1;
		end else if (go_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && end_s1) begin
			peaks_s2 <= peaks_next;
		end
	end

	assign rate_s2 = prfp_pkg::RATE_BITS'(peaks_s2) * prfp_pkg::RATE_BITS'(rate_gain_q);

	// ------------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s2) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2) begin
			peak_count_q <= peaks_s2;
			rate_q <= rate_s2;
			rate_high_q <= (rate_s2 > high_rate_limit_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(prfp_pkg::OUT_TDATA_BITS - prfp_pkg::OUT_FIELD_BITS){1'b0}},
		rate_q, peak_count_q};
	assign m_axis_tuser = rate_high_q;

`ifndef NO_ASSERTIONS
	// a peak needs two earlier samples, so counts only exist from position 3
	a_peaks_need_position: assert property (@(posedge clk) disable iff (!arst_n)
		(peaks_q != '0) |-> (pos_q >= prfp_pkg::POS_BITS'(3)))
		else $error("peak count ahead of window position");

	// a window end clears all window state
	a_end_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && end_s1) |=> (pos_q == '0) && (peaks_q == '0) && (last_q == '0))
		else $error("window state not cleared after window end");

	// a blocked stage-2 result is neither lost nor overwritten
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !go_s2) |=> valid_s2 && $stable(peaks_s2))
		else $error("stage 2 result lost while output blocked");
`endif

endmodule

// ===== tb/sv/pulse_rate_from_filtered_peaks_tb.sv =====
// ----------------------------------------------------------------------------
// pulse_rate_from_filtered_peaks_tb - self-checking bench for the pulse rate block
// drives infrared samples in random bursts, tracks the windowed ema filter and
// peak counter alongside the block, and checks every window result field by
// field against the tracked value while the result side stalls on its own
// pattern, including one long hold-off that backs the block up
// ----------------------------------------------------------------------------
module pulse_rate_from_filtered_peaks_tb;
	import prfp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;   // cycles with no request moved at all
	localparam int SETTLE_CYCLES = 10;      // extra idle time once every window result is out
	localparam int HOLD_CYCLES = 300;       // long receiver hold-off
	localparam int RANDOM_ITEMS = 120;
	localparam int RANDOM_WINDOWS = 10;

	typedef struct packed {
		logic [PEAK_BITS-1:0] peaks;
		logic [RATE_BITS-1:0] rate;
		logic                 high;
	} window_result_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_PERIODIC,
		READY_MOSTLY
	} ready_style_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic                      m_axis_tuser;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_BITS-1:0]  paddr;
	logic [APB_DATA_BITS-1:0]  pwdata;
	logic [APB_DATA_BITS-1:0]  prdata;
	logic                      pready;

	// tracked copy of the registers
	logic [GAIN_BITS-1:0]  cfg_gain;
	logic [THR_BITS-1:0]   cfg_threshold;
	logic [WLEN_BITS-1:0]  cfg_length;
	logic [RGAIN_BITS-1:0] cfg_rate_gain;
	logic [LIMIT_BITS-1:0] cfg_limit;

	// tracked copy of the window state
	sample_t              flt_last;
	sample_t              flt_before;
	int unsigned          win_pos;
	logic [PEAK_BITS-1:0] peak_tally;

	window_result_t pending_windows[$];
	int unsigned    windows_predicted;
	int unsigned    mismatch_count;
	int unsigned    idle_cycles;

	// sender burst state
	int unsigned burst_left;
	bit          steady_feed;

	// receiver pattern state
	ready_style_t ready_style;
	int unsigned  style_left;
	int unsigned  stall_tick;
	int unsigned  hold_left;
	int unsigned  hold_orders;
	int unsigned  hold_served;

	pulse_rate_from_filtered_peaks uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// advance the tracked window by one accepted sample, queue a result at window end
	task automatic track_sample(input sample_t x);
		longint unsigned g;
		longint unsigned len;
		longint unsigned f;
		longint unsigned rate;
		window_result_t r;
		g = (cfg_gain > Q16_ONE) ? longint'(Q16_ONE) : longint'(cfg_gain);
		len = cfg_length;
		if (len < WINDOW_MIN) len = WINDOW_MIN;
		if (len > WINDOW_MAX) len = WINDOW_MAX;
		if (win_pos == 0)
			f = x;
		else
			f = (g * x + (longint'(Q16_ONE) - g) * flt_last) >> Q16_SHIFT;
		// the previous sample now has both neighbours
		if (win_pos >= 2 && flt_last > flt_before && flt_last > f &&
				flt_last > cfg_threshold && peak_tally < PEAK_MAX)
			peak_tally++;
		if (win_pos + 1 >= len) begin
			rate = longint'(peak_tally) * cfg_rate_gain;
			r.peaks = peak_tally;
			r.rate = rate[RATE_BITS-1:0];
			r.high = (rate > cfg_limit);
			pending_windows.push_back(r);
			windows_predicted++;
			flt_last = '0;
			flt_before = '0;
			win_pos = 0;
			peak_tally = '0;
		end else begin
			flt_before = flt_last;
			flt_last = sample_t'(f);
			win_pos++;
		end
	endtask

	// one sample request; returns after the edge that took it and any idle gap after a burst
	task automatic send_sample(input sample_t x);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_BITS'(x);
		do @(posedge clk); while (!s_axis_tready);
		track_sample(x);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap = steady_feed ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop feeding, let every window result out and the pipe run empty
	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_BITS'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register takes the value at this edge
		case (idx)
			REG_FILTER_GAIN:     cfg_gain = value[GAIN_BITS-1:0];
			REG_PEAK_THRESHOLD:  cfg_threshold = value[THR_BITS-1:0];
			REG_WINDOW_LENGTH:   cfg_length = value[WLEN_BITS-1:0];
			REG_RATE_GAIN:       cfg_rate_gain = value[RGAIN_BITS-1:0];
			REG_HIGH_RATE_LIMIT: cfg_limit = value[LIMIT_BITS-1:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input int unsigned gain, input int unsigned thr,
			input int unsigned len, input int unsigned rgain, input int unsigned limit);
		write_reg(REG_FILTER_GAIN, gain);
		write_reg(REG_PEAK_THRESHOLD, thr);
		write_reg(REG_WINDOW_LENGTH, len);
		write_reg(REG_RATE_GAIN, rgain);
		write_reg(REG_HIGH_RATE_LIMIT, limit);
	endtask

	// triangle-shaped pulse with a little noise on top of a baseline
	function automatic sample_t pulse_point(input int unsigned base, input int unsigned amp,
			input int unsigned period, input int unsigned phase);
		longint unsigned ramp;
		longint unsigned v;
		ramp = (phase < period / 2) ? phase : period - phase;
		v = longint'(base) + ramp * amp + $urandom_range(0, amp / 4);
		if (v > {SAMPLE_BITS{1'b1}}) v = {SAMPLE_BITS{1'b1}};
		return sample_t'(v);
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// one full default window straight out of reset
	task automatic test_reset_defaults();
		for (int i = 0; i < WINDOW_LENGTH_RST; i++)
			send_sample(pulse_point(50000, 3000, 20, i % 20));
		settle_idle();
	endtask

	// extremes of sample, rate gain and limit on the shortest window
	task automatic test_field_extremes();
		apply_setting(65536, 0, 3, 65535, 0);
		send_sample('0);
		send_sample('1);
		send_sample('0);
		send_sample('1);
		send_sample('0);
		send_sample('1);
		settle_idle();
		apply_setting(65536, 0, 3, 0, 25'h1FFFFFF);
		send_sample('0);
		send_sample('1);
		send_sample('0);
		settle_idle();
	endtask

	// gain above one is clamped to one, gain of zero holds the first sample
	task automatic test_filter_gain();
		apply_setting(131071, 10, 5, 300, 299);
		send_sample(24'd100);
		send_sample(24'd900);
		send_sample(24'd20);
		send_sample(24'd800);
		send_sample(24'd5);
		settle_idle();
		apply_setting(0, 0, 5, 300, 0);
		send_sample(24'd100);
		send_sample(24'd900);
		send_sample(24'd20);
		send_sample(24'd800);
		send_sample(24'd5);
		settle_idle();
	endtask

	// window lengths below the minimum all act as three
	task automatic test_short_window();
		for (int len = 0; len < WINDOW_MIN; len++) begin
			apply_setting(65536, 0, len, 7, 6);
			send_sample(24'd1);
			send_sample(24'd9);
			send_sample(24'd2);
			settle_idle();
		end
	endtask

	// a threshold at the top of the range lets no peak through
	task automatic test_threshold_top();
		apply_setting(65536, 24'hFFFFFF, 5, 1000, 500);
		send_sample(24'd0);
		send_sample(24'hFFFFFF);
		send_sample(24'd0);
		send_sample(24'hFFFFFE);
		send_sample(24'd0);
		settle_idle();
	endtask

	// window cut short while the position is already past the new length
	task automatic test_shortened_window();
		apply_setting(40000, 100, 20, 55, 100);
		for (int i = 0; i < 10; i++)
			send_sample(pulse_point(2000, 500, 4, i % 4));
		settle_idle();
		write_reg(REG_WINDOW_LENGTH, 4);
		send_sample(24'd3000);
		settle_idle();
	endtask

	// longest window with alternating samples, most peaks a window can hold,
	// length above the maximum clamps to it
	task automatic test_full_window();
		apply_setting(65536, 0, 2047, 65535, 33553920);
		for (int i = 0; i < WINDOW_MAX; i++)
			send_sample((i % 2) ? '1 : '0);
		settle_idle();
	endtask

	// receiver holds off for a long stretch while the sender keeps going
	task automatic test_back_pressure();
		apply_setting(65536, 0, 3, 100, 50);
		hold_orders++;
		steady_feed = 1'b1;
		for (int i = 0; i < 60; i++)
			send_sample((i % 3 == 1) ? 24'd5000 : 24'd10);
		steady_feed = 1'b0;
		settle_idle();
	endtask

	// phases of random settings, mostly pulse trains, some raw noise
	task automatic test_random_traffic();
		int unsigned items_done;
		int unsigned first_window;
		int unsigned base;
		int unsigned amp;
		int unsigned period;
		int unsigned gain;
		int unsigned thr;
		int unsigned len;
		int unsigned rgain;
		int unsigned limit;
		int unsigned n;
		items_done = 0;
		first_window = windows_predicted;
		while (items_done < RANDOM_ITEMS || windows_predicted - first_window < RANDOM_WINDOWS) begin
			base = $urandom_range(0, 24'hFFFFFF);
			amp = 1 << $urandom_range(0, 20);
			period = $urandom_range(3, 12);
			case ($urandom_range(0, 3))
				0: gain = 65536;
				1: gain = $urandom_range(16384, 65536);
				2: gain = $urandom_range(0, 131071);
				default: gain = $urandom_range(40000, 65535);
			endcase
			thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
				: $urandom_range(0, base);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
				: $urandom_range(3, 24);
			rgain = $urandom_range(0, 65535);
			limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25'h1FFFFFF)
				: $urandom_range(0, rgain * 6);
			apply_setting(gain, thr, len, rgain, limit);
			n = $urandom_range(40, 80);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_sample(sample_t'($urandom));
				else
					send_sample(pulse_point(base, amp, period, i % period));
			end
			items_done += n;
			settle_idle();
		end
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	// receiver ready pattern, with the long hold-off counted here
	always @(posedge clk) begin
		stall_tick++;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_orders != hold_served) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				ready_style = ready_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(20, 80);
			end else begin
				style_left--;
			end
			case (ready_style)
				READY_ALWAYS:   m_axis_tready <= 1'b1;
				READY_COIN:     m_axis_tready <= $urandom_range(0, 1);
				READY_PERIODIC: m_axis_tready <= (stall_tick % 5) >= 2;
				default:        m_axis_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// compare each window result with the oldest one tracked
	always @(posedge clk) begin
		window_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_windows.size() == 0) begin
				mismatch_count++;
				$error("window result with none pending: tdata %h tuser %b",
					m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_windows.pop_front();
				if (m_axis_tdata[PEAK_BITS-1:0] !== want.peaks) begin
					mismatch_count++;
					$error("peak_count: expected %0d, got %0d", want.peaks,
						m_axis_tdata[PEAK_BITS-1:0]);
				end
				if (m_axis_tdata[OUT_FIELD_BITS-1:PEAK_BITS] !== want.rate) begin
					mismatch_count++;
					$error("rate_centi_bpm: expected %0d, got %0d", want.rate,
						m_axis_tdata[OUT_FIELD_BITS-1:PEAK_BITS]);
				end
				if (m_axis_tuser !== want.high) begin
					mismatch_count++;
					$error("rate_high: expected %0b, got %0b", want.high, m_axis_tuser);
				end
				if (m_axis_tdata[OUT_TDATA_BITS-1:OUT_FIELD_BITS] !== '0) begin
					mismatch_count++;
					$error("tdata padding: expected 0, got %h",
						m_axis_tdata[OUT_TDATA_BITS-1:OUT_FIELD_BITS]);
				end
			end
		end
	end

	// ends the run when no request has moved for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg_gain = FILTER_GAIN_RST;
		cfg_threshold = PEAK_THRESHOLD_RST;
		cfg_length = WINDOW_LENGTH_RST;
		cfg_rate_gain = RATE_GAIN_RST;
		cfg_limit = HIGH_RATE_LIMIT_RST;
		flt_last = '0;
		flt_before = '0;
		win_pos = 0;
		peak_tally = '0;
		windows_predicted = 0;
		mismatch_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		steady_feed = 1'b0;
		ready_style = READY_ALWAYS;
		style_left = 0;
		stall_tick = 0;
		hold_left = 0;
		hold_orders = 0;
		hold_served = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_filter_gain();
		test_short_window();
		test_threshold_top();
		test_shortened_window();
		test_full_window();
		test_back_pressure();
		test_random_traffic();

		settle_idle();
		if (mismatch_count == 0 && pending_windows.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
